FILE: rtl/sll_pkg.sv
// ----------------------------------------------------------------------------
// sll_pkg: shared types and constants of the small language lexer
// Token kinds, error codes, character codes, the keyword table and the
// record that carries one token from the scanner to the result queue.
// ----------------------------------------------------------------------------
`default_nettype none

package sll_pkg;

    localparam int QUEUE_DEPTH = 4;

    localparam logic [4:0] TK_END      = 5'd0;
    localparam logic [4:0] TK_KW_FIRST = 5'd1;
    localparam logic [4:0] TK_IDENT    = 5'd9;
    localparam logic [4:0] TK_NUMBER   = 5'd10;
    localparam logic [4:0] TK_LCOMMENT = 5'd11;
    localparam logic [4:0] TK_BCOMMENT = 5'd12;
    localparam logic [4:0] TK_PLUS     = 5'd13;
    localparam logic [4:0] TK_MINUS    = 5'd14;
    localparam logic [4:0] TK_STAR     = 5'd15;
    localparam logic [4:0] TK_SLASH    = 5'd16;
    localparam logic [4:0] TK_ASSIGN   = 5'd17;
    localparam logic [4:0] TK_EQUAL    = 5'd18;
    localparam logic [4:0] TK_LBRACE   = 5'd19;
    localparam logic [4:0] TK_RBRACE   = 5'd20;
    localparam logic [4:0] TK_GT       = 5'd21;
    localparam logic [4:0] TK_GE       = 5'd22;
    localparam logic [4:0] TK_LT       = 5'd23;
    localparam logic [4:0] TK_LE       = 5'd24;
    localparam logic [4:0] TK_LPAREN   = 5'd25;
    localparam logic [4:0] TK_RPAREN   = 5'd26;
    localparam logic [4:0] TK_SEMI     = 5'd27;

    localparam logic [1:0] ERR_NONE         = 2'd0;
    localparam logic [1:0] ERR_SECOND_POINT = 2'd1;
    localparam logic [1:0] ERR_NO_FRACTION  = 2'd2;

    localparam logic [7:0] CH_NEWLINE = 8'h0A;
    localparam logic [7:0] CH_HASH    = 8'h23;
    localparam logic [7:0] CH_LPAREN  = 8'h28;
    localparam logic [7:0] CH_RPAREN  = 8'h29;
    localparam logic [7:0] CH_STAR    = 8'h2A;
    localparam logic [7:0] CH_PLUS    = 8'h2B;
    localparam logic [7:0] CH_MINUS   = 8'h2D;
    localparam logic [7:0] CH_DOT     = 8'h2E;
    localparam logic [7:0] CH_SLASH   = 8'h2F;
    localparam logic [7:0] CH_DIGIT_0 = 8'h30;
    localparam logic [7:0] CH_DIGIT_9 = 8'h39;
    localparam logic [7:0] CH_SEMI    = 8'h3B;
    localparam logic [7:0] CH_LT      = 8'h3C;
    localparam logic [7:0] CH_EQ      = 8'h3D;
    localparam logic [7:0] CH_GT      = 8'h3E;
    localparam logic [7:0] CH_UPPER_A = 8'h41;
    localparam logic [7:0] CH_UPPER_Z = 8'h5A;
    localparam logic [7:0] CH_USCORE  = 8'h5F;
    localparam logic [7:0] CH_LOWER_A = 8'h61;
    localparam logic [7:0] CH_LOWER_Z = 8'h7A;
    localparam logic [7:0] CH_LBRACE  = 8'h7B;
    localparam logic [7:0] CH_RBRACE  = 8'h7D;

    // Keyword text, first character in the lowest byte.
    localparam logic [63:0] KW_TEXT [8] = '{
        64'h0000_0000_0000_6669,
        64'h0000_0000_6573_6C65,
        64'h0000_0000_6E69_616D,
        64'h0000_0065_6C69_6877,
        64'h0000_0000_0074_6E69,
        64'h0000_6E72_7574_6572,
        64'h0000_656C_6275_6F64,
        64'h006E_6165_6C6F_6F62
    };

    typedef struct packed {
        logic [4:0]  kind;
        logic [7:0]  length;
        logic [15:0] line;
        logic [1:0]  err;
        logic        last;
    } res_t;

    typedef struct packed {
        logic [1:0] count;
        res_t       first;
        res_t       second;
    } scan_out_t;

endpackage

`default_nettype wire

FILE: rtl/sll_scan.sv
// ----------------------------------------------------------------------------
// sll_scan: scanner state and per-character token logic
// Holds the scan state and, for the character in the input register,
// works out, combinationally, the next state and up to two finished tokens.
// ----------------------------------------------------------------------------
`default_nettype none

module sll_scan
    import sll_pkg::*;
#(
    parameter int MAX_TOKEN_LEN = 255
)
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      in_valid,
    input  wire logic [7:0] character,
    output scan_out_t      results
);

    localparam int CNT_W = $clog2(MAX_TOKEN_LEN + 1);

    typedef enum logic [3:0] {
        M_IDLE, M_WORD, M_NUM, M_NUMPT, M_SLASH, M_LCOM, M_BCOM, M_EQ, M_GT, M_LT
    } mode_t;

    mode_t              mode_reg,   mode_next;
    logic [63:0]        prefix_reg, prefix_next;
    logic [CNT_W-1:0]   count_reg,  count_next;
    logic [15:0]        line_reg,   line_next;
    logic               point_reg,  point_next;
    logic               star_reg,   star_next;
    logic               halted_reg, halted_next;

    logic [CNT_W-1:0]   count_inc;
    logic [15:0]        line_inc;
    logic               is_letter;
    logic               is_digit;
    logic [4:0]         word_kind;
    logic               consumed;
    logic               pend_valid;
    logic               start_valid;
    logic [4:0]         pend_kind;
    logic [7:0]         pend_len;
    logic [1:0]         pend_err;
    logic [4:0]         start_kind;
    logic [7:0]         start_len;
    logic [15:0]        emit_line;

    function automatic logic [7:0] len8(input logic [CNT_W-1:0] v);
        logic [7:0] r;
        if (32'(v) > 32'd255)
        begin
            r = 8'hFF;
        end
        else
        begin
            r = 8'(v);
        end
        return r;
    endfunction

    assign count_inc = (32'(count_reg) < MAX_TOKEN_LEN) ? count_reg + CNT_W'(1) : count_reg;
    assign line_inc  = (line_reg != 16'hFFFF) ? line_reg + 16'd1 : line_reg;
    assign is_letter = (character >= CH_LOWER_A && character <= CH_LOWER_Z)
                    || (character >= CH_UPPER_A && character <= CH_UPPER_Z)
                    || (character == CH_USCORE);
    assign is_digit  = (character >= CH_DIGIT_0 && character <= CH_DIGIT_9);

    always_comb
    begin
        word_kind = TK_IDENT;
        if (32'(count_reg) <= 32'd8)
        begin
            for (int k = 0; k < 8; k++)
            begin
                if (prefix_reg == KW_TEXT[k])
                begin
                    word_kind = TK_KW_FIRST + 5'(k);
                end
            end
        end
    end

    always_comb
    begin
        mode_next   = mode_reg;
        prefix_next = prefix_reg;
        count_next  = count_reg;
        line_next   = line_reg;
        point_next  = point_reg;
        star_next   = star_reg;
        halted_next = halted_reg;
        consumed    = 1'b0;
        pend_valid  = 1'b0;
        pend_kind   = TK_END;
        pend_len    = 8'd0;
        pend_err    = ERR_NONE;
        start_valid = 1'b0;
        start_kind  = TK_END;
        start_len   = 8'd0;
        emit_line   = line_reg;

        if (in_valid && !halted_reg)
        begin
            // Finish or extend the pending token, using this character as lookahead.
            unique case (mode_reg)
                M_WORD:
                begin
                    if (is_letter || is_digit)
                    begin
                        for (int i = 0; i < 8; i++)
                        begin
                            if (count_reg == CNT_W'(i))
                            begin
                                prefix_next[8*i +: 8] = character;
                            end
                        end
                        count_next = count_inc;
                        consumed   = 1'b1;
                    end
                    else
                    begin
                        pend_valid = 1'b1;
                        pend_kind  = word_kind;
                        pend_len   = len8(count_reg);
                    end
                end
                M_NUM, M_NUMPT:
                begin
                    if (is_digit)
                    begin
                        count_next = count_inc;
                        mode_next  = M_NUM;
                        consumed   = 1'b1;
                    end
                    else if (character == CH_DOT)
                    begin
                        count_next = count_inc;
                        consumed   = 1'b1;
                        if (point_reg)
                        begin
                            pend_valid  = 1'b1;
                            pend_kind   = TK_NUMBER;
                            pend_len    = len8(count_inc);
                            pend_err    = ERR_SECOND_POINT;
                            halted_next = 1'b1;
                        end
                        else
                        begin
                            point_next = 1'b1;
                            mode_next  = M_NUMPT;
                        end
                    end
                    else if (mode_reg == M_NUMPT)
                    begin
                        pend_valid  = 1'b1;
                        pend_kind   = TK_NUMBER;
                        pend_len    = len8(count_reg);
                        pend_err    = ERR_NO_FRACTION;
                        halted_next = 1'b1;
                        consumed    = 1'b1;
                    end
                    else
                    begin
                        pend_valid = 1'b1;
                        pend_kind  = TK_NUMBER;
                        pend_len   = len8(count_reg);
                    end
                end
                M_SLASH:
                begin
                    if (character == CH_SLASH || character == CH_STAR)
                    begin
                        count_next = CNT_W'(2);
                        star_next  = 1'b0;
                        mode_next  = (character == CH_SLASH) ? M_LCOM : M_BCOM;
                        consumed   = 1'b1;
                    end
                    else
                    begin
                        pend_valid = 1'b1;
                        pend_kind  = TK_SLASH;
                        pend_len   = 8'd1;
                    end
                end
                M_LCOM:
                begin
                    if (character == CH_HASH)
                    begin
                        pend_valid = 1'b1;
                        pend_kind  = TK_LCOMMENT;
                        pend_len   = len8(count_reg);
                    end
                    else if (character == CH_NEWLINE)
                    begin
                        line_next  = line_inc;
                        pend_valid = 1'b1;
                        pend_kind  = TK_LCOMMENT;
                        pend_len   = len8(count_reg);
                        mode_next  = M_IDLE;
                        consumed   = 1'b1;
                    end
                    else
                    begin
                        count_next = count_inc;
                        consumed   = 1'b1;
                    end
                end
                M_BCOM:
                begin
                    if (character == CH_HASH)
                    begin
                        pend_valid = 1'b1;
                        pend_kind  = TK_BCOMMENT;
                        pend_len   = len8(count_reg);
                    end
                    else
                    begin
                        count_next = count_inc;
                        consumed   = 1'b1;
                        if (star_reg && character == CH_SLASH)
                        begin
                            pend_valid = 1'b1;
                            pend_kind  = TK_BCOMMENT;
                            pend_len   = len8(count_inc);
                            mode_next  = M_IDLE;
                        end
                        else
                        begin
                            star_next = (character == CH_STAR);
                            if (character == CH_NEWLINE)
                            begin
                                line_next = line_inc;
                            end
                        end
                    end
                end
                M_EQ, M_GT, M_LT:
                begin
                    pend_valid = 1'b1;
                    pend_kind  = (mode_reg == M_EQ) ? TK_ASSIGN :
                                 (mode_reg == M_GT) ? TK_GT : TK_LT;
                    pend_len   = 8'd1;
                    mode_next  = M_IDLE;
                    if (character == CH_EQ)
                    begin
                        pend_kind = pend_kind + 5'd1;
                        pend_len  = 8'd2;
                        consumed  = 1'b1;
                    end
                end
                default:
                begin
                end
            endcase

            emit_line = line_next;

            // The character was not taken by the pending token, so it may start one.
            if (!consumed)
            begin
                mode_next = M_IDLE;
                if (character == CH_HASH)
                begin
                    start_valid = 1'b1;
                    start_kind  = TK_END;
                    halted_next = 1'b1;
                end
                else if (character == CH_NEWLINE)
                begin
                    line_next = line_inc;
                end
                else if (is_letter)
                begin
                    mode_next   = M_WORD;
                    count_next  = CNT_W'(1);
                    prefix_next = {56'd0, character};
                end
                else if (is_digit)
                begin
                    mode_next  = M_NUM;
                    count_next = CNT_W'(1);
                    point_next = 1'b0;
                end
                else if (character == CH_SLASH)
                begin
                    mode_next = M_SLASH;
                end
                else if (character == CH_EQ)
                begin
                    mode_next = M_EQ;
                end
                else if (character == CH_GT)
                begin
                    mode_next = M_GT;
                end
                else if (character == CH_LT)
                begin
                    mode_next = M_LT;
                end
                else
                begin
                    start_len = 8'd1;
                    unique case (character)
                        CH_PLUS:   begin start_valid = 1'b1; start_kind = TK_PLUS;   end
                        CH_MINUS:  begin start_valid = 1'b1; start_kind = TK_MINUS;  end
                        CH_STAR:   begin start_valid = 1'b1; start_kind = TK_STAR;   end
                        CH_LBRACE: begin start_valid = 1'b1; start_kind = TK_LBRACE; end
                        CH_RBRACE: begin start_valid = 1'b1; start_kind = TK_RBRACE; end
                        CH_LPAREN: begin start_valid = 1'b1; start_kind = TK_LPAREN; end
                        CH_RPAREN: begin start_valid = 1'b1; start_kind = TK_RPAREN; end
                        CH_SEMI:   begin start_valid = 1'b1; start_kind = TK_SEMI;   end
                        default:
                        begin
                        end
                    endcase
                end
            end
        end
    end

    always_comb
    begin
        results.count       = 2'({1'b0, pend_valid} + {1'b0, start_valid});
        results.second.kind   = start_kind;
        results.second.length = start_len;
        results.second.line   = emit_line;
        results.second.err    = ERR_NONE;
        results.second.last   = 1'b1;
        if (pend_valid)
        begin
            results.first.kind   = pend_kind;
            results.first.length = pend_len;
            results.first.line   = emit_line;
            results.first.err    = pend_err;
            results.first.last   = !start_valid;
        end
        else
        begin
            results.first = results.second;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= M_IDLE;
            prefix_reg <= 64'd0;
            count_reg  <= '0;
            line_reg   <= 16'd1;
            point_reg  <= 1'b0;
            star_reg   <= 1'b0;
            halted_reg <= 1'b0;
        end
        else
        begin
            mode_reg   <= mode_next;
            prefix_reg <= prefix_next;
            count_reg  <= count_next;
            line_reg   <= line_next;
            point_reg  <= point_next;
            star_reg   <= star_next;
            halted_reg <= halted_next;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/sll_queue.sv
// ----------------------------------------------------------------------------
// sll_queue: result queue of the small language lexer
// A short shifting queue that takes up to two tokens a cycle and hands
// them out one per transfer, head always in the first entry.
// ----------------------------------------------------------------------------
`default_nettype none

module sll_queue
    import sll_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire scan_out_t push,
    output logic [2:0]     count,
    output logic           head_valid,
    input  wire logic      head_ready,
    output res_t           head
);

    res_t       entry_reg [QUEUE_DEPTH];
    res_t       entry_next [QUEUE_DEPTH];
    logic [2:0] count_reg, count_next;
    logic [2:0] base;
    logic       pop;

    assign pop        = (count_reg != 3'd0) && head_ready;
    assign base       = count_reg - {2'd0, pop};
    assign count_next = base + {1'b0, push.count};

    always_comb
    begin
        for (int i = 0; i < QUEUE_DEPTH; i++)
        begin
            entry_next[i] = entry_reg[i];
        end
        if (pop)
        begin
            for (int i = 0; i < QUEUE_DEPTH - 1; i++)
            begin
                entry_next[i] = entry_reg[i + 1];
            end
        end
        for (int i = 0; i < QUEUE_DEPTH; i++)
        begin
            if (push.count != 2'd0 && base == 3'(i))
            begin
                entry_next[i] = push.first;
            end
            if (push.count == 2'd2 && base + 3'd1 == 3'(i))
            begin
                entry_next[i] = push.second;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < QUEUE_DEPTH; i++)
        begin
            entry_reg[i] <= entry_next[i];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= 3'd0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    assign count      = count_reg;
    assign head_valid = (count_reg != 3'd0);
    assign head       = entry_reg[0];

endmodule

`default_nettype wire

FILE: rtl/small_language_lexer.sv
// ----------------------------------------------------------------------------
// small_language_lexer: streaming lexer for a small C-like language
// Takes one source character per transfer and emits keyword, identifier,
// number, comment, operator and end tokens with their length and line.
// ----------------------------------------------------------------------------
// Usage
//   s_axis carries one source byte per transfer in tdata.  m_axis carries
//   one token per transfer; tlast marks the final token caused by one byte.
//   A token is known only when the byte after it arrives.  The byte that
//   ends it is held in the input register, and the token is then stored in
//   the result queue before it appears on m_axis.
//   Throughput is one character per cycle while the queue has room.  A byte
//   that ends a token and starts an operator yields two tokens, which leave
//   at one per cycle while m_axis_tready is high; the four-entry result queue
//   then fills and s_axis_tready drops until it has room for two more tokens.
//   While m_axis_tready is low tokens wait in the queue and input stops once
//   it is nearly full; no token is lost.  After '#' or a malformed number the
//   lexer keeps taking bytes but drops them until reset.  Reset empties the
//   queue, sets the line to one and returns the scanner to idle.
// ----------------------------------------------------------------------------
`default_nettype none

module small_language_lexer
    import sll_pkg::*;
#(
    parameter int MAX_TOKEN_LEN = 255
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // [7:0] character
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [31:0]      m_axis_tdata,   // [4:0] token_kind, [12:5] token_length,
                                             // [28:13] line_number, [30:29] error_code
    output logic             m_axis_tlast
);

    logic       valid_reg;
    logic [7:0] char_reg;
    logic [2:0] queue_count;
    scan_out_t  scan_results;
    res_t       head;

    assign s_axis_tready = ({1'b0, queue_count} + {2'd0, scan_results.count})
                           <= 4'(QUEUE_DEPTH - 2);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= s_axis_tvalid && s_axis_tready;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
        begin
            char_reg <= s_axis_tdata;
        end
    end

    sll_scan #(
        .MAX_TOKEN_LEN (MAX_TOKEN_LEN)
    ) u_scan (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (valid_reg),
        .character (char_reg),
        .results   (scan_results)
    );

    sll_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (scan_results),
        .count      (queue_count),
        .head_valid (m_axis_tvalid),
        .head_ready (m_axis_tready),
        .head       (head)
    );

    assign m_axis_tdata = {1'b0, head.err, head.line, head.length, head.kind};
    assign m_axis_tlast = head.last;

endmodule

`default_nettype wire
